// File: hdl/swspd_pkg.sv
// Shared types and constants for the single-wire sensor pulse decoder.
`default_nettype none
package swspd_pkg;
   localparam int EDGE_W       = 7;
   localparam int RUN_W        = 16;
   localparam int FRAME_W      = 40;
   localparam int CNT_W        = 6;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 16;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = 2;

   localparam logic [EDGE_W-1:0] MAX_EDGES  = 7'd100;
   localparam logic [CNT_W-1:0]  FRAME_BITS = 6'd40;

   localparam logic OP_START = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_SENSOR_TYPE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BIT_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_TICKS = 2'd2;

   localparam logic              SENSOR_TYPE_RST   = 1'b1;
   localparam logic [RUN_W-1:0]  BIT_THRESHOLD_RST = 16'd200;
   localparam logic [RUN_W-1:0]  TIMEOUT_TICKS_RST = 16'd1000;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_SHORT    = 2'd1;
   localparam logic [1:0] ST_CHECKSUM = 2'd2;

   typedef struct packed {
      logic             sensor_type;
      logic [RUN_W-1:0] bit_threshold;
      logic [RUN_W-1:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic arm;
      logic bit_vld;
      logic bit_val;
      logic finish;
   } event_type;
endpackage
`default_nettype wire

// File: hdl/single_wire_sensor_pulse_decoder.sv
// Single-wire sensor pulse decoder, top level.
// Request channel: req_valid/req_stall carry req_opcode (start or tick)
// and req_line_level, one sampled line level per tick item.
// Result channel: rsp_valid/rsp_stall carry status, humidity, temperature
// and bit count; one result when a read ends by timeout or edge limit.
// CSR channel: csr_valid/csr_ready with csr_index and csr_wdata; always
// ready; index 0 sensor type, 1 bit threshold, 2 timeout ticks.
// Throughput: one item per cycle while req_stall is low. The front end
// classifies each sample in the cycle it is taken and pushes events into
// a four-entry queue; the assembler drains one event per cycle unless a
// held result blocks a finish event. The ending sample's finish event is
// written into the queue, and the result register takes it when popped.
// When rsp_stall holds a result, the assembler stops at the next finish
// event, the queue fills, and req_stall rises once it is full.
// Reset clears the front end to idle, empties the queue, drops any result
// and loads the CSR reset values (type 1, threshold 200, timeout 1000).
`default_nettype none
module single_wire_sensor_pulse_decoder (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic                                  req_opcode,
   input  wire logic                                  req_line_level,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [1:0]                                 rsp_status,
   output logic [15:0]                                rsp_humidity_tenths,
   output logic signed [15:0]                         rsp_temperature_tenths,
   output logic [5:0]                                 rsp_bits_received,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [swspd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [swspd_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import swspd_pkg::*;

   cfg_type   cfg_ff;
   logic      q_push, q_pop, q_full, q_empty;
   event_type q_event, q_head;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sensor_type   <= SENSOR_TYPE_RST;
         cfg_ff.bit_threshold <= BIT_THRESHOLD_RST;
         cfg_ff.timeout_ticks <= TIMEOUT_TICKS_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SENSOR_TYPE:   cfg_ff.sensor_type   <= csr_wdata[0];
            CSR_BIT_THRESHOLD: cfg_ff.bit_threshold <= csr_wdata;
            CSR_TIMEOUT_TICKS: cfg_ff.timeout_ticks <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   swspd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_valid      (req_valid),
      .req_opcode     (req_opcode),
      .req_line_level (req_line_level),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_event        (q_event)
   );

   swspd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_event (q_event),
      .pop        (q_pop),
      .full       (q_full),
      .empty      (q_empty),
      .head       (q_head)
   );

   swspd_back u_back (
      .clock                  (clock),
      .reset                  (reset),
      .cfg                    (cfg_ff),
      .q_empty                (q_empty),
      .q_head                 (q_head),
      .q_pop                  (q_pop),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_status             (rsp_status),
      .rsp_humidity_tenths    (rsp_humidity_tenths),
      .rsp_temperature_tenths (rsp_temperature_tenths),
      .rsp_bits_received      (rsp_bits_received)
   );
endmodule
`default_nettype wire

// File: hdl/swspd_front.sv
// Front end: run measurement and bit classification of line samples.
`default_nettype none
module swspd_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire swspd_pkg::cfg_type  cfg,
   input  wire logic                req_valid,
   input  wire logic                req_opcode,
   input  wire logic                req_line_level,
   input  wire logic                q_full,
   output logic                     q_push,
   output swspd_pkg::event_type     q_event
);
   import swspd_pkg::*;

   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_WAIT    = 2'd1;
   localparam logic [1:0] PH_MEASURE = 2'd2;

   logic [1:0]        phase_ff, phase_in;
   logic              prev_ff, prev_in;
   logic [RUN_W-1:0]  run_ff, run_in;
   logic [EDGE_W-1:0] edge_ff, edge_in;
   logic              accept;

   assign accept = req_valid && !q_full;

   always_comb begin
      logic              rec_en;
      logic [RUN_W-1:0]  rec_len;
      logic [RUN_W-1:0]  run_inc;
      logic [RUN_W-1:0]  limit;
      logic [EDGE_W-1:0] edge_nxt;
      event_type         ev;
      phase_in = phase_ff;
      prev_in  = prev_ff;
      run_in   = run_ff;
      edge_in  = edge_ff;
      rec_en   = 1'b0;
      rec_len  = '0;
      ev       = '0;
      run_inc  = run_ff + 16'd1;
      limit    = (cfg.timeout_ticks == '0) ? 16'd1 : cfg.timeout_ticks;
      edge_nxt = edge_ff + 7'd1;
      if (accept) begin
         if (req_opcode == OP_START) begin
            phase_in = PH_WAIT;
            prev_in  = 1'b1;
            run_in   = '0;
            edge_in  = '0;
            ev.arm   = 1'b1;
         end else begin
            case (phase_ff)
               PH_WAIT: begin
                  if (!req_line_level) begin
                     phase_in = PH_MEASURE;
                     prev_in  = 1'b0;
                     run_in   = '0;
                     rec_en   = 1'b1;
                  end
               end
               PH_MEASURE: begin
                  if (req_line_level == prev_ff) begin
                     run_in = run_inc;
                     if (run_inc >= limit) begin
                        ev.finish = 1'b1;
                        phase_in  = PH_IDLE;
                     end
                  end else begin
                     prev_in = req_line_level;
                     run_in  = '0;
                     rec_en  = 1'b1;
                     rec_len = run_ff;
                  end
               end
               default: begin
               end
            endcase
         end
      end
      if (rec_en) begin
         if (edge_ff > 7'd3 && !edge_ff[0]) begin
            ev.bit_vld = 1'b1;
            ev.bit_val = rec_len > cfg.bit_threshold;
         end
         edge_in = edge_nxt;
         if (edge_nxt >= MAX_EDGES) begin
            ev.finish = 1'b1;
            phase_in  = PH_IDLE;
         end
      end
      q_event = ev;
      q_push  = ev.arm || ev.bit_vld || ev.finish;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         prev_ff  <= 1'b1;
         run_ff   <= '0;
         edge_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         prev_ff  <= prev_in;
         run_ff   <= run_in;
         edge_ff  <= edge_in;
      end
   end
endmodule
`default_nettype wire

// File: hdl/swspd_queue.sv
// Short event queue between the front end and the frame assembler.
`default_nettype none
module swspd_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire swspd_pkg::event_type  push_event,
   input  wire logic                  pop,
   output logic                       full,
   output logic                       empty,
   output swspd_pkg::event_type       head
);
   import swspd_pkg::*;

   event_type         mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in;
   logic [QPTR_W-1:0] rd_ff, rd_in;
   logic [QPTR_W:0]   cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign full    = cnt_ff == QUEUE_DEPTH[QPTR_W:0];
   assign empty   = cnt_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem[rd_ff];

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + {{QPTR_W{1'b0}}, do_push} - {{QPTR_W{1'b0}}, do_pop};
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ff] <= push_event;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QUEUE_DEPTH[QPTR_W:0])
      else $error("queue count beyond depth");
   assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");
   assert property (@(posedge clock) disable iff (reset)
      (wr_ff - rd_ff) == cnt_ff[QPTR_W-1:0])
      else $error("queue pointers disagree with count");
endmodule
`default_nettype wire

// File: hdl/swspd_back.sv
// Back end: frame assembly, checksum check, conversion and result register.
`default_nettype none
module swspd_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire swspd_pkg::cfg_type    cfg,
   input  wire logic                  q_empty,
   input  wire swspd_pkg::event_type  q_head,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [1:0]                 rsp_status,
   output logic [15:0]                rsp_humidity_tenths,
   output logic signed [15:0]         rsp_temperature_tenths,
   output logic [5:0]                 rsp_bits_received
);
   import swspd_pkg::*;

   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               valid_ff, valid_in;
   logic [1:0]         status_ff, status_in;
   logic [15:0]        hum_ff, hum_in;
   logic [15:0]        temp_ff, temp_in;
   logic [CNT_W-1:0]   bits_ff;

   assign q_pop = !q_empty && (!q_head.finish || !valid_ff || !rsp_stall);

   always_comb begin
      logic [7:0]  b0, b1, b2, b3, b4, sum;
      logic [14:0] mag;
      frame_in = frame_ff;
      count_in = count_ff;
      if (q_pop) begin
         if (q_head.arm) begin
            frame_in = '0;
            count_in = '0;
         end
         if (q_head.bit_vld && count_ff < FRAME_BITS) begin
            frame_in = {frame_ff[FRAME_W-2:0], q_head.bit_val};
            count_in = count_ff + 6'd1;
         end
      end
      b0  = frame_in[39:32];
      b1  = frame_in[31:24];
      b2  = frame_in[23:16];
      b3  = frame_in[15:8];
      b4  = frame_in[7:0];
      sum = b0 + b1 + b2 + b3;
      mag = {b2[6:0], b3};
      status_in = ST_OK;
      hum_in    = '0;
      temp_in   = '0;
      if (count_in < FRAME_BITS) begin
         status_in = ST_SHORT;
      end else if (sum != b4) begin
         status_in = ST_CHECKSUM;
      end else if (cfg.sensor_type) begin
         hum_in  = {b0, b1};
         temp_in = b2[7] ? 16'd0 - {1'b0, mag} : {1'b0, mag};
      end else begin
         hum_in  = {5'd0, b1, 3'd0} + {7'd0, b1, 1'b0};
         temp_in = {5'd0, b2, 3'd0} + {7'd0, b2, 1'b0};
      end
      if (q_pop && q_head.finish) begin
         valid_in = 1'b1;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         frame_ff <= frame_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && q_head.finish) begin
         status_ff <= status_in;
         hum_ff    <= hum_in;
         temp_ff   <= temp_in;
         bits_ff   <= count_in;
      end
   end

   assign rsp_valid              = valid_ff;
   assign rsp_status             = status_ff;
   assign rsp_humidity_tenths    = hum_ff;
   assign rsp_temperature_tenths = temp_ff;
   assign rsp_bits_received      = bits_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= FRAME_BITS)
      else $error("bit count beyond frame length");
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && status_ff != ST_OK |-> hum_ff == '0 && temp_ff == '0)
      else $error("failed read carries nonzero values");
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && status_ff != ST_SHORT |-> bits_ff == FRAME_BITS)
      else $error("full-frame status with short bit count");
endmodule
`default_nettype wire
